// ----- rtl/b64lw_pkg.sv -----
package b64lw_pkg;

   // Register reset value and queue sizing.
   localparam logic [7:0] LINE_WIDTH_RESET = 8'd72;
   localparam int unsigned QUEUE_DEPTH = 2;

   // Fixed characters of the output stream.
   localparam logic [7:0] CHAR_LF = 8'd10;
   localparam logic [7:0] CHAR_PAD = 8'd61;

   // Characters a group gives before an optional line feed.
   localparam logic [8:0] GROUP_CHARS = 9'd4;

   // Number of bytes held in the partial group.
   typedef enum logic [1:0] {
      PH_EMPTY,
      PH_ONE,
      PH_TWO
   } phase_type;

   // Index of the character being sent within one job.
   typedef enum logic [2:0] {
      CI_SYM0,
      CI_SYM1,
      CI_SYM2,
      CI_SYM3,
      CI_LF
   } char_idx_type;

   // One unit of work for the back end: four characters and an optional line feed.
   typedef struct packed {
      logic [23:0] bits;
      logic [1:0]  pad_count;
      logic        line_feed;
      logic        last;
   } job_type;

   // Maps a six-bit code to its standard base64 alphabet character.
   function automatic logic [7:0] b64_char(input logic [5:0] code);
      logic [7:0] wide;
      logic [7:0] result;
      wide = {2'b00, code};
      case (code) inside
         [6'd0:6'd25]:  result = wide + 8'd65;
         [6'd26:6'd51]: result = wide + 8'd71;
         [6'd52:6'd61]: result = wide - 8'd4;
         6'd62:         result = 8'd43;
         default:       result = 8'd47;
      endcase
      return result;
   endfunction

endpackage

// ----- rtl/b64lw_if.sv -----
// Byte channel into the encoder.
interface b64lw_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       last_byte;

   modport source(output valid, output data_byte, output last_byte, input ready);
   modport sink(input valid, input data_byte, input last_byte, output ready);
endinterface

// Character channel out of the encoder.
interface b64lw_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] out_char;
   logic       last_char;

   modport source(output valid, output out_char, output last_char, input ready);
   modport sink(input valid, input out_char, input last_char, output ready);
endinterface

// ----- rtl/base64_line_wrapped_encoder.sv -----
// Base64 encoder with line wrapping: bytes enter on req_bus, one per beat, with last_byte on the
// final byte of a message, and standard base64 characters leave on rsp_bus, one per beat. Every
// three bytes give four characters, and a line feed follows a group once the column count reaches
// line_width (written through csr_wr_en/csr_wr_data, reset 72). The last byte flushes a partial
// group padded with '=' and a closing line feed when the line is open; last_char marks the final
// character of that byte. The front end takes a byte every cycle while its job queue has room; the
// back end sends one character per cycle while the receiver is ready. The first character of a
// group goes out through the job queue and then the output register.
module base64_line_wrapped_encoder #(
   parameter int unsigned QUEUE_DEPTH = b64lw_pkg::QUEUE_DEPTH
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_wr_en,
   input  logic [7:0]  csr_wr_data,
   b64lw_req_if.sink   req_bus,
   b64lw_rsp_if.source rsp_bus
);

   logic [7:0]          line_width_ff;
   logic                push;
   logic                pop;
   logic                full;
   logic                head_valid;
   b64lw_pkg::job_type  push_job;
   b64lw_pkg::job_type  head_job;

   // Line width register.
   always_ff @(posedge clock) begin
      if (reset) begin
         line_width_ff <= b64lw_pkg::LINE_WIDTH_RESET;
      end else if (csr_wr_en) begin
         line_width_ff <= csr_wr_data;
      end
   end

   b64lw_front u_front (
      .clock      (clock),
      .reset      (reset),
      .line_width (line_width_ff),
      .req        (req_bus),
      .queue_full (full),
      .push       (push),
      .push_job   (push_job)
   );

   b64lw_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_job   (push_job),
      .full       (full),
      .pop        (pop),
      .head_valid (head_valid),
      .head_job   (head_job)
   );

   b64lw_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (head_valid),
      .head_job   (head_job),
      .pop        (pop),
      .rsp        (rsp_bus)
   );

endmodule

// ----- rtl/b64lw_front.sv -----
// Gathers bytes into groups, tracks the line column and issues jobs.
module b64lw_front (
   input  logic                 clock,
   input  logic                 reset,
   input  logic [7:0]           line_width,
   b64lw_req_if.sink            req,
   input  logic                 queue_full,
   output logic                 push,
   output b64lw_pkg::job_type   push_job
);

   b64lw_pkg::phase_type phase_ff, phase_in;
   logic [15:0] held_ff, held_in;
   logic [7:0]  column_ff, column_in;
   logic        accept;
   logic [8:0]  sum;
   logic        wrap;

   assign req.ready = !queue_full;
   assign accept = req.valid && !queue_full;

   // Column after a full group and whether the line ends there.
   assign sum = {1'b0, column_ff} + b64lw_pkg::GROUP_CHARS;
   assign wrap = sum >= {1'b0, line_width};

   // Next phase, held bytes and column.
   always_comb begin
      phase_in = phase_ff;
      held_in = held_ff;
      column_in = column_ff;
      if (accept) begin
         case (phase_ff)
            b64lw_pkg::PH_EMPTY: begin
               held_in = {req.data_byte, 8'h00};
               phase_in = b64lw_pkg::PH_ONE;
            end
            b64lw_pkg::PH_ONE: begin
               held_in = {held_ff[15:8], req.data_byte};
               phase_in = b64lw_pkg::PH_TWO;
            end
            default: begin
               held_in = 16'h0000;
               phase_in = b64lw_pkg::PH_EMPTY;
               column_in = wrap ? 8'h00 : sum[7:0];
            end
         endcase
         if (req.last_byte) begin
            held_in = 16'h0000;
            phase_in = b64lw_pkg::PH_EMPTY;
            column_in = 8'h00;
         end
      end
   end

   // Job for the back end: a full group, or the padded tail at message end.
   always_comb begin
      push_job.last = req.last_byte;
      case (phase_ff)
         b64lw_pkg::PH_EMPTY: begin
            push_job.bits = {req.data_byte, 16'h0000};
            push_job.pad_count = 2'd2;
            push_job.line_feed = column_ff != 8'h00;
         end
         b64lw_pkg::PH_ONE: begin
            push_job.bits = {held_ff[15:8], req.data_byte, 8'h00};
            push_job.pad_count = 2'd1;
            push_job.line_feed = column_ff != 8'h00;
         end
         default: begin
            // The column after a group that does not wrap is never zero.
            push_job.bits = {held_ff, req.data_byte};
            push_job.pad_count = 2'd0;
            push_job.line_feed = wrap || req.last_byte;
         end
      endcase
      push = accept && (req.last_byte || phase_ff == b64lw_pkg::PH_TWO);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= b64lw_pkg::PH_EMPTY;
         held_ff <= 16'h0000;
         column_ff <= 8'h00;
      end else begin
         phase_ff <= phase_in;
         held_ff <= held_in;
         column_ff <= column_in;
      end
   end

endmodule

// ----- rtl/b64lw_queue.sv -----
// Small job queue between the front and back ends.
module b64lw_queue #(
   parameter int unsigned DEPTH = b64lw_pkg::QUEUE_DEPTH
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   input  b64lw_pkg::job_type   push_job,
   output logic                 full,
   input  logic                 pop,
   output logic                 head_valid,
   output b64lw_pkg::job_type   head_job
);

   localparam int unsigned PtrWidth = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CountWidth = $clog2(DEPTH + 1);
   localparam logic [PtrWidth-1:0] LastSlot = PtrWidth'(DEPTH - 1);
   localparam logic [CountWidth-1:0] FullCount = CountWidth'(DEPTH);

   b64lw_pkg::job_type slot_ff [DEPTH];
   logic [PtrWidth-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PtrWidth-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CountWidth-1:0] count_ff, count_in;

   assign full = count_ff == FullCount;
   assign head_valid = count_ff != '0;
   assign head_job = slot_ff[rd_ptr_ff];

   // Pointer and fill count updates.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == LastSlot) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == LastSlot) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
   end

   // Job storage.
   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_job;
      end
   end

endmodule

// ----- rtl/b64lw_back.sv -----
// Sends job characters, one per cycle unless stalled, through an output register.
module b64lw_back (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 head_valid,
   input  b64lw_pkg::job_type   head_job,
   output logic                 pop,
   b64lw_rsp_if.source          rsp
);

   b64lw_pkg::char_idx_type idx_ff, idx_in;
   b64lw_pkg::char_idx_type final_idx;
   logic       valid_ff, valid_in;
   logic [7:0] char_ff, char_in;
   logic       last_ff, last_in;
   logic       load;
   logic       at_end;

   assign rsp.valid = valid_ff;
   assign rsp.out_char = char_ff;
   assign rsp.last_char = last_ff;

   // The output register takes a new beat when it is empty or being drained.
   assign load = head_valid && (!valid_ff || rsp.ready);
   assign final_idx = head_job.line_feed ? b64lw_pkg::CI_LF : b64lw_pkg::CI_SYM3;
   assign at_end = idx_ff == final_idx;
   assign pop = load && at_end;

   // Character selection for the current index.
   always_comb begin
      case (idx_ff)
         b64lw_pkg::CI_SYM0: char_in = b64lw_pkg::b64_char(head_job.bits[23:18]);
         b64lw_pkg::CI_SYM1: char_in = b64lw_pkg::b64_char(head_job.bits[17:12]);
         b64lw_pkg::CI_SYM2: begin
            char_in = (head_job.pad_count == 2'd2) ? b64lw_pkg::CHAR_PAD
                                                   : b64lw_pkg::b64_char(head_job.bits[11:6]);
         end
         b64lw_pkg::CI_SYM3: begin
            char_in = (head_job.pad_count != 2'd0) ? b64lw_pkg::CHAR_PAD
                                                   : b64lw_pkg::b64_char(head_job.bits[5:0]);
         end
         default: char_in = b64lw_pkg::CHAR_LF;
      endcase
      last_in = head_job.last && at_end;
   end

   // Index and valid updates.
   always_comb begin
      idx_in = idx_ff;
      valid_in = valid_ff;
      if (load) begin
         valid_in = 1'b1;
         idx_in = at_end ? b64lw_pkg::CI_SYM0 : b64lw_pkg::char_idx_type'(idx_ff + 3'd1);
      end else if (rsp.ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff <= b64lw_pkg::CI_SYM0;
         valid_ff <= 1'b0;
      end else begin
         idx_ff <= idx_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         char_ff <= char_in;
         last_ff <= last_in;
      end
   end

endmodule

// ----- rtl/b64lw_checker.sv -----
// Port-level checks for the encoder.
module b64lw_checker (
   input logic       clock,
   input logic       reset,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [7:0] rsp_out_char,
   input logic       rsp_last_char
);

   // A stalled beat keeps its character.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_out_char) && $stable(rsp_last_char))
      else $error("Stalled response beat changed.");

   // No response beat comes out of reset.
   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("Response valid right after reset.");

   // A message always ends on padding or a line feed.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_last_char |->
         rsp_out_char == b64lw_pkg::CHAR_PAD || rsp_out_char == b64lw_pkg::CHAR_LF)
      else $error("Last character is neither padding nor line feed.");

   // Padding is only ever followed by padding, a line feed, or a new message.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && rsp_out_char == b64lw_pkg::CHAR_PAD && !rsp_last_char
         ##1 rsp_valid |->
         rsp_out_char == b64lw_pkg::CHAR_PAD || rsp_out_char == b64lw_pkg::CHAR_LF)
      else $error("Padding followed by an alphabet character.");

endmodule

bind base64_line_wrapped_encoder b64lw_checker u_checker (
   .clock         (clock),
   .reset         (reset),
   .rsp_valid     (rsp_bus.valid),
   .rsp_ready     (rsp_bus.ready),
   .rsp_out_char  (rsp_bus.out_char),
   .rsp_last_char (rsp_bus.last_char)
);

// ----- dv/tb.sv -----
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   // Receiver behavior for one stretch of the run.
   typedef enum logic [1:0] {
      RX_OPEN,
      RX_RANDOM,
      RX_PATTERN
   } rx_mode_type;

   // One character the encoder is expected to send.
   typedef struct {
      logic [7:0] ch;
      logic       last;
   } char_beat_type;

   // One row of the directed stimulus. A width of -1 leaves the register alone; rows with
   // typed set carry their expected characters, the others go through the predictor.
   typedef struct {
      logic [7:0] data;
      logic       last;
      int         width;
      bit         typed;
      string      chars;
   } stim_row_type;

   localparam int DIR_ROWS = 26;
   localparam int RAND_BYTES = 154;
   localparam int SETTLE_CYCLES = 8;
   localparam int MAX_REPORTS = 10;

   logic clock = 1'b0;
   logic reset;
   logic csr_wr_en;
   logic [7:0] csr_wr_data;

   b64lw_req_if req_bus ();
   b64lw_rsp_if rsp_bus ();

   base64_line_wrapped_encoder u_top (
      .clock      (clock),
      .reset      (reset),
      .csr_wr_en  (csr_wr_en),
      .csr_wr_data(csr_wr_data),
      .req_bus    (req_bus),
      .rsp_bus    (rsp_bus)
   );

   // Directed stimulus: padding of one and two bytes, full groups, the reset width, then
   // narrow, zero and full widths, and a width change in the middle of an open line.
   stim_row_type dir_rows [DIR_ROWS] = '{
      '{8'h00, 1'b1, -1, 1'b1, "AA=="},
      '{8'hFF, 1'b1, -1, 1'b1, "/w=="},
      '{8'hFF, 1'b0, -1, 1'b1, ""},
      '{8'hFF, 1'b1, -1, 1'b1, "//8="},
      '{8'h00, 1'b0, -1, 1'b1, ""},
      '{8'h00, 1'b0, -1, 1'b1, ""},
      '{8'h00, 1'b1, -1, 1'b1, "AAAA\n"},
      '{8'h4D, 1'b0, -1, 1'b1, ""},
      '{8'h61, 1'b0, -1, 1'b1, ""},
      '{8'h6E, 1'b0, -1, 1'b1, "TWFu"},
      '{8'hFF, 1'b0, -1, 1'b1, ""},
      '{8'hFF, 1'b0, -1, 1'b1, ""},
      '{8'hFF, 1'b1, -1, 1'b1, "////\n"},
      '{8'h01, 1'b0, 4, 1'b1, ""},
      '{8'h02, 1'b0, -1, 1'b1, ""},
      '{8'h03, 1'b0, -1, 1'b1, "AQID\n"},
      '{8'h80, 1'b1, -1, 1'b1, "gA=="},
      '{8'hAA, 1'b0, 0, 1'b0, ""},
      '{8'h55, 1'b0, -1, 1'b0, ""},
      '{8'hC3, 1'b1, -1, 1'b0, ""},
      '{8'h12, 1'b0, 255, 1'b0, ""},
      '{8'h34, 1'b0, -1, 1'b0, ""},
      '{8'h56, 1'b0, -1, 1'b0, ""},
      '{8'h9A, 1'b0, 4, 1'b0, ""},
      '{8'hBC, 1'b0, -1, 1'b0, ""},
      '{8'hDE, 1'b1, -1, 1'b0, ""}
   };

   // Predictor state and the characters still owed by the encoder.
   logic [15:0]           enc_held;
   b64lw_pkg::phase_type  enc_phase;
   logic [7:0]            enc_col;
   logic [7:0]            enc_width;
   char_beat_type         pending_chars[$];

   // Run bookkeeping.
   int err_count = 0;
   int bytes_sent = 0;
   int msgs_sent = 0;
   int chars_seen = 0;
   int lf_seen = 0;
   int width_writes = 0;
   int burst_left = 0;
   bit gaps_on = 1'b1;
   rx_mode_type rx_mode = RX_RANDOM;
   logic [7:0] stall_pat = 8'b1011_0111;

   // Clock with a 10 ns period.
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic logic [7:0] alpha_char(input logic [5:0] code);
      string alphabet;
      alphabet = "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";
      return alphabet[code];
   endfunction

   function automatic void push_char(input logic [7:0] ch);
      char_beat_type beat;
      beat.ch = ch;
      beat.last = 1'b0;
      pending_chars.push_back(beat);
   endfunction

   // Works out the characters that one accepted byte causes and advances the predictor.
   function automatic void encode_byte(input logic [7:0] data, input logic last);
      logic [23:0]   grp;
      logic [8:0]    sum;
      int            first;
      char_beat_type tail;
      first = pending_chars.size();
      case (enc_phase)
         b64lw_pkg::PH_EMPTY: begin
            enc_held = {data, 8'h00};
            enc_phase = b64lw_pkg::PH_ONE;
         end
         b64lw_pkg::PH_ONE: begin
            enc_held[7:0] = data;
            enc_phase = b64lw_pkg::PH_TWO;
         end
         default: begin
            grp = {enc_held, data};
            push_char(alpha_char(grp[23:18]));
            push_char(alpha_char(grp[17:12]));
            push_char(alpha_char(grp[11:6]));
            push_char(alpha_char(grp[5:0]));
            sum = {1'b0, enc_col} + b64lw_pkg::GROUP_CHARS;
            if (sum >= {1'b0, enc_width}) begin
               push_char(b64lw_pkg::CHAR_LF);
               enc_col = 8'd0;
            end else begin
               enc_col = sum[7:0];
            end
            enc_held = 16'd0;
            enc_phase = b64lw_pkg::PH_EMPTY;
         end
      endcase

      // The last byte flushes a partial group and closes an open line.
      if (last) begin
         if (enc_phase != b64lw_pkg::PH_EMPTY) begin
            grp = {enc_held, 8'h00};
            push_char(alpha_char(grp[23:18]));
            push_char(alpha_char(grp[17:12]));
            push_char((enc_phase == b64lw_pkg::PH_TWO) ? alpha_char(grp[11:6])
                                                       : b64lw_pkg::CHAR_PAD);
            push_char(b64lw_pkg::CHAR_PAD);
         end
         if (enc_col != 8'd0) push_char(b64lw_pkg::CHAR_LF);
         if (pending_chars.size() > first) begin
            tail = pending_chars.pop_back();
            tail.last = 1'b1;
            pending_chars.push_back(tail);
         end
         enc_held = 16'd0;
         enc_phase = b64lw_pkg::PH_EMPTY;
         enc_col = 8'd0;
      end
   endfunction

   function automatic void report(input string what, input logic [8:0] want,
                                  input logic [8:0] got);
      err_count++;
      if (err_count <= MAX_REPORTS) begin
         $display("%0t: %s: expected char 0x%02h last %0d, got char 0x%02h last %0d",
                  $realtime, what, want[8:1], want[0], got[8:1], got[0]);
      end
   endfunction

   // Presents one byte, honoring the sender's bursts and gaps, and records what it should
   // produce once the beat is taken. Returns at the falling edge after the accept.
   task automatic send_byte(input logic [7:0] data, input logic last, input bit typed,
                            input string chars);
      int held_n;
      char_beat_type beat;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 16);
         if (gaps_on) begin
            req_bus.valid = 1'b0;
            repeat ($urandom_range(1, 5)) @(negedge clock);
         end
      end
      burst_left--;
      req_bus.valid = 1'b1;
      req_bus.data_byte = data;
      req_bus.last_byte = last;
      do @(posedge clock); while (!req_bus.ready);

      // Typed rows still step the predictor so its state follows the stream.
      held_n = pending_chars.size();
      encode_byte(data, last);
      if (typed) begin
         while (pending_chars.size() > held_n) void'(pending_chars.pop_back());
         for (int i = 0; i < chars.len(); i++) begin
            beat.ch = chars[i];
            beat.last = last && (i == chars.len() - 1);
            pending_chars.push_back(beat);
         end
      end
      bytes_sent++;
      if (last) msgs_sent++;
      @(negedge clock);
   endtask

   // Waits until the encoder has nothing left to send, then writes the line width.
   task automatic settle_and_write(input logic [7:0] width);
      req_bus.valid = 1'b0;
      while (pending_chars.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      @(negedge clock);
      csr_wr_en = 1'b1;
      csr_wr_data = width;
      enc_width = width;
      width_writes++;
      @(negedge clock);
      csr_wr_en = 1'b0;
   endtask

   // Receiver stalls, changed at the falling edge.
   always @(negedge clock) begin
      case (rx_mode)
         RX_OPEN: rsp_bus.ready = 1'b1;
         RX_RANDOM: rsp_bus.ready = ($urandom_range(0, 99) >= 35);
         default: begin
            rsp_bus.ready = stall_pat[0];
            stall_pat = {stall_pat[0], stall_pat[7:1]};
         end
      endcase
   end

   // Every character beat is compared with the oldest expectation.
   always @(posedge clock) begin
      char_beat_type want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         chars_seen++;
         if (rsp_bus.out_char == b64lw_pkg::CHAR_LF) lf_seen++;
         if (pending_chars.size() == 0) begin
            report("unexpected character", 9'd0, {rsp_bus.out_char, rsp_bus.last_char});
         end else begin
            want = pending_chars.pop_front();
            if (want.ch !== rsp_bus.out_char || want.last !== rsp_bus.last_char) begin
               report("character mismatch", {want.ch, want.last},
                      {rsp_bus.out_char, rsp_bus.last_char});
            end
         end
      end
   end

   // Main sequence: reset, directed table, random phases, drain.
   initial begin
      int n;
      int wait_cycles;
      logic [7:0] width;
      logic last;

      reset = 1'b1;
      csr_wr_en = 1'b0;
      csr_wr_data = 8'd0;
      req_bus.valid = 1'b0;
      req_bus.data_byte = 8'd0;
      req_bus.last_byte = 1'b0;
      rsp_bus.ready = 1'b0;
      enc_held = 16'd0;
      enc_phase = b64lw_pkg::PH_EMPTY;
      enc_col = 8'd0;
      enc_width = b64lw_pkg::LINE_WIDTH_RESET;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed table.
      foreach (dir_rows[r]) begin
         if (dir_rows[r].width >= 0) settle_and_write(dir_rows[r].width[7:0]);
         send_byte(dir_rows[r].data, dir_rows[r].last, dir_rows[r].typed, dir_rows[r].chars);
      end

      // Random phases, each with its own width, sender gaps and receiver stalls. Messages
      // run across phase boundaries, so widths also change in the middle of a line.
      for (int phase_idx = 0; bytes_sent < DIR_ROWS + RAND_BYTES; phase_idx++) begin
         case ($urandom_range(0, 7))
            0: width = 8'd4;
            1: width = 8'd252;
            2: width = 8'd0;
            3: width = 8'd255;
            4: width = 8'd1;
            5: width = b64lw_pkg::LINE_WIDTH_RESET;
            6: width = 8'($urandom_range(4, 252));
            default: width = 8'($urandom_range(4, 24));
         endcase
         if (phase_idx == 0) width = 8'd252;
         rx_mode = rx_mode_type'($urandom_range(0, 2));
         gaps_on = ($urandom_range(0, 3) != 0);
         stall_pat = 8'($urandom_range(0, 255)) | 8'h01;
         settle_and_write(width);
         n = $urandom_range(8, 40);
         for (int i = 0; i < n && bytes_sent < DIR_ROWS + RAND_BYTES; i++) begin
            last = ($urandom_range(0, 7) == 0) || (bytes_sent == DIR_ROWS + RAND_BYTES - 1);
            send_byte(8'($urandom_range(0, 255)), last, 1'b0, "");
         end
      end
      req_bus.valid = 1'b0;

      // Drain, then allow the pipeline to show anything extra.
      wait_cycles = 0;
      while (pending_chars.size() != 0 && wait_cycles < 5000) begin
         @(posedge clock);
         wait_cycles++;
      end
      repeat (20) @(posedge clock);
      if (pending_chars.size() != 0) begin
         err_count += pending_chars.size();
         $display("%0d expected characters never arrived", pending_chars.size());
      end

      $display("Encoded %0d bytes in %0d messages under %0d line width settings.",
               bytes_sent, msgs_sent, width_writes);
      $display("Checked %0d characters, %0d of them line feeds; %0d failures.",
               chars_seen, lf_seen, err_count);
      if (err_count == 0) begin
         $display("base64_line_wrapped_encoder verification clean");
      end else begin
         $display("base64_line_wrapped_encoder verification failed");
      end
      $finish;
   end

   // Watchdog for a hung handshake.
   initial begin
      #2_000_000;
      $display("Timed out with %0d characters outstanding.", pending_chars.size());
      $display("base64_line_wrapped_encoder verification failed");
      $finish;
   end

endmodule
